// ===== rtl/core/crc32_combine_engine_assert.svh =====
// Assertion macros for the CRC-32 combine engine.
// Included by the top level; depends on nothing else.
`ifndef CRC32_COMBINE_ENGINE_ASSERT_SVH
`define CRC32_COMBINE_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CCOMB_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CCOMB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ccomb_pkg.sv =====
// Package for the CRC-32 combine engine: widths, pipeline item type and
// the GF(2) operator functions used to build the constant zero-byte operators.
package ccomb_pkg;

    localparam int CRC_W       = 32;
    localparam int LEN_W       = 32;
    localparam int LENGTH_BITS = 32;
    // Length bits that can matter: the port is only LEN_W wide.
    localparam int LEN_USED    = (LENGTH_BITS < LEN_W) ? LENGTH_BITS : LEN_W;
    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB88320;

    // Operator matrix: entry k is the image of input bit k.
    typedef logic [CRC_W-1:0][CRC_W-1:0] mat_t;

    // One item traveling down the pipeline.
    typedef struct packed {
        logic                valid;
        logic                nz;      // masked length was nonzero
        logic [CRC_W-1:0]    crc;     // running first CRC
        logic [CRC_W-1:0]    crc2;    // second CRC, XORed in at the end
        logic [LEN_USED-1:0] len;     // remaining length bits, LSB is next
    } stage_t;

    // Matrix times vector over GF(2).
    function automatic logic [CRC_W-1:0] gf_apply(mat_t m, logic [CRC_W-1:0] v);
        logic [CRC_W-1:0] acc;
        acc = '0;
        for (int k = 0; k < CRC_W; k++) begin
            if (v[k]) begin
                acc = acc ^ m[k];
            end
        end
        return acc;
    endfunction

    // Matrix squared.
    function automatic mat_t gf_square(mat_t m);
        mat_t r;
        for (int k = 0; k < CRC_W; k++) begin
            r[k] = gf_apply(m, m[k]);
        end
        return r;
    endfunction

    // Operator that advances a CRC over 2**k zero bytes (2**(k+3) zero bits).
    // Only called with constant arguments, evaluated at elaboration.
    function automatic mat_t zero_op(int k);
        mat_t m;
        m[0] = CRC_POLY;
        for (int i = 1; i < CRC_W; i++) begin
            m[i] = CRC_W'(1) << (i - 1);
        end
        for (int i = 0; i < k + 3; i++) begin
            m = gf_square(m);
        end
        return m;
    endfunction

endpackage

// ===== rtl/core/ccomb_stage.sv =====
// One pipeline stage of the CRC-32 combine engine: applies a fixed
// zero-byte operator when the current length bit is set. Uses ccomb_pkg.
module ccomb_stage
    import ccomb_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   en,        // pipeline advance
    input  mat_t   op,        // constant operator for this length bit
    input  stage_t item_in,
    output stage_t item_out
);

    stage_t stage_reg;
    stage_t stage_next;

    // Apply the operator on a set length bit, then move to the next bit.
    always_comb begin
        stage_next     = item_in;
        stage_next.len = item_in.len >> 1;
        if (item_in.len[0]) begin
            stage_next.crc = gf_apply(op, item_in.crc);
        end
    end

    // Valid bit: cleared by reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg.valid <= 1'b0;
        end else if (en) begin
            stage_reg.valid <= stage_next.valid;
        end
    end

    // Payload: no reset.
    always_ff @(posedge aclk) begin
        if (en) begin
            stage_reg.nz   <= stage_next.nz;
            stage_reg.crc  <= stage_next.crc;
            stage_reg.crc2 <= stage_next.crc2;
            stage_reg.len  <= stage_next.len;
        end
    end

    assign item_out = stage_reg;

endmodule

// ===== rtl/core/crc32_combine_engine.sv =====
// Top level of the CRC-32 combine engine: input register, one operator
// stage per length bit, output register. Uses ccomb_pkg and ccomb_stage.
//
//   channel | direction | handshake          | payload
//   s_      | in        | s_valid / s_ready  | s_crc_first, s_crc_second, s_second_length
//   m_      | out       | m_valid / m_ready  | m_crc_joined
//
// Pipeline: one input register, one stage per length bit, one output register.
// An item can enter every cycle while the output is not stalled.
// The whole pipeline freezes while the output holds an item that is not taken.
// Reset (aresetn low, synchronous) clears the valid bits only.
module crc32_combine_engine
    import ccomb_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [CRC_W-1:0] s_crc_first,
    input  logic [CRC_W-1:0] s_crc_second,
    input  logic [LEN_W-1:0] s_second_length,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [CRC_W-1:0] m_crc_joined
);

    logic             advance;
    stage_t           pipe [LEN_USED+1];
    stage_t           in_reg;
    stage_t           in_next;
    logic             out_valid_reg;
    logic [CRC_W-1:0] out_crc_reg;
    logic [CRC_W-1:0] out_crc_next;
    stage_t           last;

    // Global advance: move when the output slot is free or being taken.
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = advance;

    // Input capture.
    always_comb begin
        in_next       = '0;
        in_next.valid = s_valid;
        in_next.crc   = s_crc_first;
        in_next.crc2  = s_crc_second;
        in_next.len   = s_second_length[LEN_USED-1:0];
        in_next.nz    = |s_second_length[LEN_USED-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_reg.valid <= 1'b0;
        end else if (advance) begin
            in_reg.valid <= in_next.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            in_reg.nz   <= in_next.nz;
            in_reg.crc  <= in_next.crc;
            in_reg.crc2 <= in_next.crc2;
            in_reg.len  <= in_next.len;
        end
    end

    assign pipe[0] = in_reg;

    // One stage per length bit, each with its constant operator.
    for (genvar k = 0; k < LEN_USED; k++) begin : g_stage
        localparam mat_t OP = zero_op(k);
        ccomb_stage u_stage (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (advance),
            .op       (OP),
            .item_in  (pipe[k]),
            .item_out (pipe[k+1])
        );
    end

    assign last = pipe[LEN_USED];

    // Zero length keeps the first CRC as is; otherwise XOR in the second.
    assign out_crc_next = last.nz ? (last.crc ^ last.crc2) : last.crc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= last.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_crc_reg <= out_crc_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_crc_joined = out_crc_reg;

    // Checks on pipeline control and the final combine.
`include "crc32_combine_engine_assert.svh"

    `CCOMB_ASSERT_NEXT(a_freeze, aclk, aresetn, m_valid && !m_ready, $stable(in_reg.valid) && $stable(last.crc), "pipeline moved while output stalled")
    `CCOMB_ASSERT_NEXT(a_zero_len, aclk, aresetn, advance && last.valid && !last.nz, m_valid && m_crc_joined == $past(last.crc), "zero-length item altered")
    `CCOMB_ASSERT_NEXT(a_join, aclk, aresetn, advance && last.valid && last.nz, m_valid && m_crc_joined == $past(last.crc ^ last.crc2), "second CRC not combined")
    `CCOMB_ASSERT_NOW(a_ready, aclk, aresetn, !m_valid, s_ready, "input blocked with empty output")

endmodule
